[rtl/core/cstat_pkg.sv]
// Shared widths, bounds and control/status bundles for the column statistics block.
package cstat_pkg;

  localparam int MAX_ROWS       = 1024;
  localparam int DISTINCT_DEPTH = 256;

  localparam int VAL_W  = 32;
  localparam int SUM_W  = 42;
  localparam int AVG_W  = 40;
  localparam int FRAC_W = 8;
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int DST_W  = $clog2(DISTINCT_DEPTH + 1);
  localparam int ADDR_W = $clog2(DISTINCT_DEPTH);
  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int DIVC_W = $clog2(DIV_W);

  typedef struct packed {
    logic load;
    logic update;
    logic search;
    logic insert;
    logic div_load;
    logic div_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic last;
    logic hit;
    logic miss;
    logic div_done;
  } status_t;

endpackage

[rtl/core/cstat_ctrl.sv]
// Sequencer for the column statistics block: item intake, distinct scan, division, result.
module cstat_ctrl import cstat_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t st,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_UPDATE   = 6'b000010,
    S_SEARCH   = 6'b000100,
    S_DIV_LOAD = 6'b001000,
    S_DIV_RUN  = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (st.take) begin
          state_nxt = S_SEARCH;
        end else if (st.last) begin
          state_nxt = S_DIV_LOAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (st.hit || st.miss) begin
          cmd.insert = st.miss && !st.hit;
          state_nxt  = st.last ? S_DIV_LOAD : S_IDLE;
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (st.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

endmodule

[rtl/core/cstat_dp.sv]
// Datapath: running extremes, sum and counts, distinct-value store and serial divider.
module cstat_dp import cstat_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output status_t                 st,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_is_null,
  input  logic                    in_last,
  output logic signed [VAL_W-1:0] col_max,
  output logic signed [VAL_W-1:0] col_min,
  output logic signed [SUM_W-1:0] col_sum,
  output logic signed [AVG_W-1:0] col_average,
  output logic [CNT_W-1:0]        non_null_count,
  output logic [DST_W-1:0]        distinct_count,
  output logic                    all_null,
  output logic                    distinct_full,
  output logic                    rows_dropped
);

  logic signed [VAL_W-1:0] val_r;
  logic                    null_r;
  logic                    last_r;
  logic signed [VAL_W-1:0] max_r;
  logic signed [VAL_W-1:0] min_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        valid_r;
  logic [CNT_W-1:0]        row_r;
  logic [DST_W-1:0]        seen_r;
  logic                    full_r;
  logic                    drop_r;

  logic [DST_W-1:0]        idx_r;
  logic                    pend_r;
  logic [VAL_W-1:0]        rdata_r;
  logic [VAL_W-1:0]        mem [DISTINCT_DEPTH];

  logic [DIV_W-1:0]        dq_r;
  logic [CNT_W-1:0]        rem_r;
  logic [DIVC_W-1:0]       dcnt_r;
  logic                    neg_r;

  logic                    in_bound;
  logic                    store_room;
  logic [SUM_W-1:0]        sum_mag;
  logic [CNT_W:0]          trial;
  logic                    q_bit;
  logic [AVG_W-1:0]        quot;

  assign in_bound   = (row_r < CNT_W'(MAX_ROWS));
  assign store_room = (seen_r < DST_W'(DISTINCT_DEPTH));
  assign sum_mag    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign trial      = {rem_r, dq_r[DIV_W-1]};
  assign q_bit      = (trial >= {1'b0, valid_r});

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= in_value;
      null_r <= in_is_null;
      last_r <= in_last;
    end
  end

  // running statistics
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      max_r   <= '0;
      min_r   <= '0;
      sum_r   <= '0;
      valid_r <= '0;
      row_r   <= '0;
      seen_r  <= '0;
      full_r  <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (!in_bound) begin
          drop_r <= 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
          if (!null_r) begin
            if (valid_r == '0) begin
              max_r <= val_r;
              min_r <= val_r;
            end else begin
              if (val_r > max_r) max_r <= val_r;
              if (val_r < min_r) min_r <= val_r;
            end
            sum_r   <= sum_r + SUM_W'(val_r);
            valid_r <= valid_r + 1'b1;
          end
        end
      end
      if (cmd.insert) begin
        if (store_room) begin
          seen_r <= seen_r + 1'b1;
        end else begin
          full_r <= 1'b1;
        end
      end
    end
  end

  // distinct scan: one stored entry read per cycle, compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.update) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.search) begin
      if (idx_r < seen_r) begin
        idx_r  <= idx_r + 1'b1;
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && store_room) begin
      mem[seen_r[ADDR_W-1:0]] <= val_r;
    end
    if (cmd.search && (idx_r < seen_r)) begin
      rdata_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_load) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= sum_r[SUM_W-1];
      dq_r  <= {sum_mag, {FRAC_W{1'b0}}};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[DIV_W-2:0], q_bit};
      rem_r <= q_bit ? CNT_W'(trial - {1'b0, valid_r}) : trial[CNT_W-1:0];
    end
  end

  assign st.take     = in_bound && !null_r;
  assign st.last     = last_r;
  assign st.hit      = pend_r && (rdata_r == val_r);
  assign st.miss     = !pend_r && (idx_r >= seen_r);
  assign st.div_done = (dcnt_r == DIVC_W'(DIV_W - 1));

  assign quot           = dq_r[AVG_W-1:0];
  assign col_max        = max_r;
  assign col_min        = min_r;
  assign col_sum        = sum_r;
  assign col_average    = (valid_r == '0) ? '0 : (neg_r ? -quot : quot);
  assign non_null_count = valid_r;
  assign distinct_count = seen_r;
  assign all_null       = (valid_r == '0);
  assign distinct_full  = full_r;
  assign rows_dropped   = drop_r;

endmodule

[rtl/core/column_statistics.sv]
// Top level of the column statistics block: sequencer plus datapath.
//
// Cells enter one at a time on start while busy is low. A null cell, or one past the
// row bound of 1024, skips the distinct scan. A non-null cell within the bound is
// compared against the distinct values already stored (up to 256); a new value is
// added while room is left, and a match on a stored entry ends the scan early. The
// distinct store has one read port and is scanned one entry per cycle. After the
// cell marked last, the divider is loaded and runs the bit-serial division that
// forms the average, and then the result is presented. The result appears on the
// out_ ports for exactly one cycle with out_valid high and cannot be held off, so
// the receiver must take it then; all statistics clear afterwards for the next
// column.
module column_statistics import cstat_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_is_null,
  input  logic                    in_last,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_col_max,
  output logic signed [VAL_W-1:0] out_col_min,
  output logic signed [SUM_W-1:0] out_col_sum,
  output logic signed [AVG_W-1:0] out_col_average,
  output logic [CNT_W-1:0]        out_non_null_count,
  output logic [DST_W-1:0]        out_distinct_count,
  output logic                    out_all_null,
  output logic                    out_distinct_full,
  output logic                    out_rows_dropped
);

  cmd_t    cmd;
  status_t st;

  cstat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cstat_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_value       (in_value),
    .in_is_null     (in_is_null),
    .in_last        (in_last),
    .col_max        (out_col_max),
    .col_min        (out_col_min),
    .col_sum        (out_col_sum),
    .col_average    (out_col_average),
    .non_null_count (out_non_null_count),
    .distinct_count (out_distinct_count),
    .all_null       (out_all_null),
    .distinct_full  (out_distinct_full),
    .rows_dropped   (out_rows_dropped)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block not idle after result");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (out_non_null_count == '0 && out_distinct_count == '0))
    else $error("statistics not cleared after result");

  a_distinct_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(out_distinct_count) <= out_non_null_count)
    else $error("distinct count exceeds non-null count");
`endif

endmodule

[bench/column_statistics_test.sv]
// Self-checking bench for column_statistics: directed and random columns against a predictor.
`timescale 1ns / 100ps

module column_statistics_test;
  import cstat_pkg::*;

  localparam logic [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam int TOTAL_CELLS = 1350;
  localparam int TAIL_CYCLES = 400;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             is_null;
    logic             last;
    logic             drain;   // hold this item back until every result is in
  } cell_t;

  typedef struct {
    logic signed [VAL_W-1:0] col_max;
    logic signed [VAL_W-1:0] col_min;
    logic signed [SUM_W-1:0] col_sum;
    logic signed [AVG_W-1:0] col_average;
    logic [CNT_W-1:0]        non_null_count;
    logic [DST_W-1:0]        distinct_count;
    logic                    all_null;
    logic                    distinct_full;
    logic                    rows_dropped;
  } stats_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    in_is_null = 1'b0;
  logic                    in_last = 1'b0;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_col_max;
  logic signed [VAL_W-1:0] out_col_min;
  logic signed [SUM_W-1:0] out_col_sum;
  logic signed [AVG_W-1:0] out_col_average;
  logic [CNT_W-1:0]        out_non_null_count;
  logic [DST_W-1:0]        out_distinct_count;
  logic                    out_all_null;
  logic                    out_distinct_full;
  logic                    out_rows_dropped;

  column_statistics u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_value(in_value),
    .in_is_null(in_is_null),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_col_max(out_col_max),
    .out_col_min(out_col_min),
    .out_col_sum(out_col_sum),
    .out_col_average(out_col_average),
    .out_non_null_count(out_non_null_count),
    .out_distinct_count(out_distinct_count),
    .out_all_null(out_all_null),
    .out_distinct_full(out_distinct_full),
    .out_rows_dropped(out_rows_dropped)
  );

  always #4 clk = ~clk;

  cell_t  cells_to_send[$];
  stats_t stats_due[$];
  cell_t  next_cell;
  logic   item_taken = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;

  int queued = 0;
  int columns = 0;
  int cells_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int all_null_cols = 0;
  int full_cols = 0;
  int drop_cols = 0;

  // running column statistics as the block should hold them
  logic signed [VAL_W-1:0] run_max;
  logic signed [VAL_W-1:0] run_min;
  logic signed [SUM_W-1:0] run_sum;
  int unsigned             valid_cnt;
  int unsigned             row_cnt;
  int unsigned             seen_n;
  logic [VAL_W-1:0]        seen_vals [DISTINCT_DEPTH];
  logic                    dist_full;
  logic                    rows_drop;

  task automatic clear_column();
    run_max   = '0;
    run_min   = '0;
    run_sum   = '0;
    valid_cnt = 0;
    row_cnt   = 0;
    seen_n    = 0;
    dist_full = 1'b0;
    rows_drop = 1'b0;
  endtask

  task automatic account_cell(input logic signed [VAL_W-1:0] v, input logic nul,
                              input logic lst);
    stats_t s;
    longint total;
    longint mag;
    longint q;
    bit     found;
    int     i;
    if (row_cnt >= MAX_ROWS) begin
      rows_drop = 1'b1;
    end else begin
      row_cnt++;
      if (!nul) begin
        if (valid_cnt == 0) begin
          run_max = v;
          run_min = v;
        end else begin
          if (v > run_max) run_max = v;
          if (v < run_min) run_min = v;
        end
        run_sum = run_sum + v;
        valid_cnt++;
        found = 1'b0;
        for (i = 0; i < seen_n; i++)
          if (seen_vals[i] == v) found = 1'b1;
        if (!found) begin
          if (seen_n < DISTINCT_DEPTH) begin
            seen_vals[seen_n] = v;
            seen_n++;
          end else begin
            dist_full = 1'b1;
          end
        end
      end
    end
    if (lst) begin
      total = run_sum;
      q = 0;
      if (valid_cnt != 0) begin
        // Q.8 average, truncated toward zero
        mag = (total < 0) ? -total : total;
        q = (mag <<< FRAC_W) / longint'(valid_cnt);
        if (total < 0) q = -q;
      end
      s.col_max        = run_max;
      s.col_min        = run_min;
      s.col_sum        = run_sum;
      s.col_average    = q[AVG_W-1:0];
      s.non_null_count = valid_cnt[CNT_W-1:0];
      s.distinct_count = seen_n[DST_W-1:0];
      s.all_null       = (valid_cnt == 0);
      s.distinct_full  = dist_full;
      s.rows_dropped   = rows_drop;
      stats_due.insert(stats_due.size(), s);
      clear_column();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_cell(input logic [VAL_W-1:0] v, input logic nul, input logic lst,
                          input logic drn);
    cell_t c;
    c.value   = v;
    c.is_null = nul;
    c.last    = lst;
    c.drain   = drn;
    cells_to_send.insert(cells_to_send.size(), c);
    queued++;
  endtask

  task automatic add_column(input bit long_col, input bit drn);
    int               len;
    int               npct;
    int               k;
    int               pick;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] v;
    if (long_col) begin
      // runs past the row bound and overfills the distinct store
      len  = MAX_ROWS + $urandom_range(1, 8);
      npct = 25;
    end else begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0: npct = 0;
        1: npct = 20;
        2: npct = 60;
        default: npct = ($urandom_range(0, 1) == 1) ? 100 : 10;
      endcase
    end
    base = $urandom;
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (long_col) begin
        v = (pick < 70) ? base + $urandom_range(0, 299) : $urandom;
      end else if (pick < 40) begin
        v = $urandom;
      end else if (pick < 70) begin
        v = base + $urandom_range(0, 5);
      end else if (pick < 85) begin
        v = $urandom_range(0, 15) - 32'd8;
      end else begin
        case ($urandom_range(0, 4))
          0: v = INT_MIN;
          1: v = INT_MIN + 1;
          2: v = INT_MAX - 1;
          3: v = INT_MAX;
          default: v = '1;
        endcase
      end
      add_cell(v, $urandom_range(0, 99) < npct, k == len - 1, drn && k == 0);
    end
    columns++;
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !item_taken)) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        in_value <= $urandom;
        gap_left--;
      end else if (cells_to_send.size() == 0 ||
                   (cells_to_send[0].drain && stats_due.size() != 0)) begin
        start <= 1'b0;
      end else begin
        next_cell   = cells_to_send.pop_front();
        in_value   <= next_cell.value;
        in_is_null <= next_cell.is_null;
        in_last    <= next_cell.last;
        start      <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 80);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left   = $urandom_range(1, 8);
        end
      end
    end
  end

  // monitor: results checked and accepted items predicted on the rising edge
  always @(posedge clk) begin : monitor
    stats_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (stats_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no column pending", $time);
          mismatches++;
        end else begin
          want = stats_due.pop_front();
          results_seen++;
          if (want.all_null) all_null_cols++;
          if (want.distinct_full) full_cols++;
          if (want.rows_dropped) drop_cols++;
          check_field("col_max", want.col_max, out_col_max);
          check_field("col_min", want.col_min, out_col_min);
          check_field("col_sum", want.col_sum, out_col_sum);
          check_field("col_average", want.col_average, out_col_average);
          check_field("non_null_count", want.non_null_count, out_non_null_count);
          check_field("distinct_count", want.distinct_count, out_distinct_count);
          check_field("all_null", want.all_null, out_all_null);
          check_field("distinct_full", want.distinct_full, out_distinct_full);
          check_field("rows_dropped", want.rows_dropped, out_rows_dropped);
        end
      end
      if (start && !busy) begin
        account_cell(in_value, in_is_null, in_last);
        cells_taken++;
      end
    end
    item_taken <= rst_n && start && !busy;
  end

  initial begin : stimulus
    bit long_done;
    bit first_rand;
    long_done  = 1'b0;
    first_rand = 1'b1;
    clear_column();

    // all null, with junk in the value field
    add_cell(32'h1234_5678, 1'b1, 1'b0, 1'b0);
    add_cell(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);
    // single cell at the negative extreme
    add_cell(INT_MIN, 1'b0, 1'b1, 1'b0);
    // both extremes, a repeat, a null in between and a null last cell
    add_cell(INT_MAX, 1'b0, 1'b0, 1'b0);
    add_cell(INT_MIN, 1'b0, 1'b0, 1'b0);
    add_cell(32'h5A5A_5A5A, 1'b1, 1'b0, 1'b0);
    add_cell(INT_MAX, 1'b0, 1'b0, 1'b0);
    add_cell('0, 1'b1, 1'b1, 1'b0);
    // negative average that truncates toward zero
    add_cell(32'd1, 1'b0, 1'b0, 1'b0);
    add_cell(-32'sd2, 1'b0, 1'b0, 1'b0);
    add_cell('0, 1'b0, 1'b1, 1'b0);
    // large negative and positive sums
    repeat (3) add_cell(INT_MIN, 1'b0, 1'b0, 1'b0);
    add_cell(INT_MIN, 1'b0, 1'b1, 1'b0);
    repeat (2) add_cell(INT_MAX - 1, 1'b0, 1'b0, 1'b0);
    add_cell(INT_MAX - 1, 1'b0, 1'b1, 1'b0);
    // zero sum
    add_cell('1, 1'b0, 1'b0, 1'b0);
    add_cell(32'd1, 1'b0, 1'b1, 1'b0);
    // lone null
    add_cell('0, 1'b1, 1'b1, 1'b0);

    while (queued < TOTAL_CELLS) begin
      if (!long_done && queued >= 200) begin
        add_column(1'b1, 1'b1);
        long_done = 1'b1;
      end else begin
        add_column(1'b0, first_rand || $urandom_range(0, 4) == 0);
        first_rand = 1'b0;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (cells_to_send.size() != 0 || start) @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d cells in %0d random and 8 directed columns, %0d results checked",
             cells_taken, columns, results_seen);
    $display("columns all null: %0d, distinct store overflowed: %0d, rows dropped: %0d",
             all_null_cols, full_cols, drop_cols);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timed out with %0d results outstanding", stats_due.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

[column_statistics.f]
rtl/core/cstat_pkg.sv
rtl/core/cstat_ctrl.sv
rtl/core/cstat_dp.sv
rtl/core/column_statistics.sv
bench/column_statistics_test.sv
